// File: hdl/bfsp_pkg.sv
// Shared definitions for the Bellman-Ford shortest path block.
// Holds sizes, codes, storage entry formats and the controller/datapath
// command and status bundles. Depends on nothing.
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 32;

  localparam int VTX_BITS  = $clog2(MAX_VERTICES);
  localparam int VCNT_BITS = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int ECNT_BITS = $clog2(MAX_EDGES + 1);

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 7;
  localparam int S_DATA_BITS   = 32;
  localparam int M_DATA_BITS   = 48;

  localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_VERTEX = 1'd1;

  localparam logic [VCNT_BITS-1:0] VCOUNT_RESET = VCNT_BITS'(MAX_VERTICES);

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_RUN    = 1'b1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

  // One stored edge, laid out as the request data: tail in the lowest bits.
  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [VTX_BITS-1:0]    to;
    logic [VTX_BITS-1:0]    from;
  } edge_t;

  // One vertex table entry.
  typedef struct packed {
    logic                 reach;
    logic                 has_par;
    logic [VTX_BITS-1:0]  parent;
    logic [DIST_BITS-1:0] cost;
  } vtx_entry_t;

  // One result, lowest field in the lowest bits.
  typedef struct packed {
    logic                 edges_dropped;
    logic                 negative_cycle;
    logic [VTX_BITS-1:0]  parent;
    logic                 has_parent;
    logic                 reachable;
    logic [DIST_BITS-1:0] distance;
    logic [VTX_BITS-1:0]  vertex;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FETCH,
    ST_EDGE,
    ST_RELAX,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic edge_wr;
    logic run_start;
    logic init_wr;
    logic v_clr;
    logic v_inc;
    logic k_clr;
    logic k_inc;
    logic pass_clr;
    logic pass_inc;
    logic relax_commit;
    logic neg_set;
    logic rd_vertex;
    logic out_load;
    logic store_clr;
  } cmd_t;

  typedef struct packed {
    logic v_last;
    logic edges_empty;
    logic k_last;
    logic relax_ok;
    logic changed_any;
    logic pass_last;
    logic src_ok;
    logic nv_one;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/bfsp_ctrl.sv
// Sequencing state machine of the Bellman-Ford shortest path block.
// Drives datapath commands from datapath status; uses bfsp_pkg.
module bfsp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tuser,
  output logic            s_tready,
  input  bfsp_pkg::sts_t  sts,
  output bfsp_pkg::cmd_t  cmd
);

  bfsp_pkg::state_t state, state_next;
  logic chk, chk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfsp_pkg::ST_IDLE;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      chk   <= chk_next;
    end
  end

  always_comb begin
    state_next = state;
    chk_next   = chk;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      bfsp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == bfsp_pkg::FUNC_RUN) begin
            cmd.run_start = 1'b1;
            chk_next      = 1'b0;
            state_next    = bfsp_pkg::ST_INIT;
          end else begin
            cmd.edge_wr = 1'b1;
          end
        end
      end
      bfsp_pkg::ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.v_last) begin
          cmd.v_clr    = 1'b1;
          cmd.k_clr    = 1'b1;
          cmd.pass_clr = 1'b1;
          if (!sts.src_ok || sts.edges_empty) begin
            state_next = bfsp_pkg::ST_EMIT_RD;
          end else begin
            // With a single vertex there are no relaxation passes.
            chk_next   = sts.nv_one;
            state_next = bfsp_pkg::ST_FETCH;
          end
        end
      end
      bfsp_pkg::ST_FETCH: begin
        state_next = bfsp_pkg::ST_EDGE;
      end
      bfsp_pkg::ST_EDGE: begin
        state_next = bfsp_pkg::ST_RELAX;
      end
      bfsp_pkg::ST_RELAX: begin
        state_next = bfsp_pkg::ST_FETCH;
        if (!chk) begin
          cmd.relax_commit = 1'b1;
          if (sts.k_last) begin
            cmd.k_clr = 1'b1;
            if (sts.changed_any && !sts.pass_last) begin
              cmd.pass_inc = 1'b1;
            end else begin
              chk_next = 1'b1;
            end
          end else begin
            cmd.k_inc = 1'b1;
          end
        end else begin
          if (sts.relax_ok || sts.k_last) begin
            cmd.neg_set = sts.relax_ok;
            state_next  = bfsp_pkg::ST_EMIT_RD;
          end else begin
            cmd.k_inc = 1'b1;
          end
        end
      end
      bfsp_pkg::ST_EMIT_RD: begin
        cmd.rd_vertex = 1'b1;
        state_next    = bfsp_pkg::ST_EMIT_LD;
      end
      bfsp_pkg::ST_EMIT_LD: begin
        cmd.rd_vertex = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.v_last) begin
            cmd.store_clr = 1'b1;
            state_next    = bfsp_pkg::ST_IDLE;
          end else begin
            cmd.v_inc  = 1'b1;
            state_next = bfsp_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = bfsp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/bfsp_dp.sv
// Datapath of the Bellman-Ford shortest path block: edge store, vertex
// table, counters, relaxation arithmetic and the result register.
// Uses bfsp_pkg; commanded by bfsp_ctrl.
module bfsp_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bfsp_pkg::cmd_t                      cmd,
  output bfsp_pkg::sts_t                      sts,
  input  logic [bfsp_pkg::VCNT_BITS-1:0]      nv,
  input  logic [bfsp_pkg::VTX_BITS-1:0]       src,
  input  logic [bfsp_pkg::S_DATA_BITS-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [bfsp_pkg::M_DATA_BITS-1:0]    m_tdata,
  output logic                                m_tlast
);

  localparam int SUM_BITS = bfsp_pkg::DIST_BITS + 1;
  localparam int EXT_BITS = SUM_BITS - bfsp_pkg::WEIGHT_BITS;

  bfsp_pkg::edge_t      edge_mem [bfsp_pkg::MAX_EDGES];
  bfsp_pkg::vtx_entry_t vtx_mem  [bfsp_pkg::MAX_VERTICES];

  logic [bfsp_pkg::ECNT_BITS-1:0] edge_count;
  logic                           overflow;
  logic [bfsp_pkg::EDGE_AW-1:0]   k;
  logic [bfsp_pkg::VTX_BITS-1:0]  v;
  logic [bfsp_pkg::VCNT_BITS-1:0] pass;
  logic                           changed;
  logic                           neg;

  bfsp_pkg::edge_t      e_q;
  bfsp_pkg::vtx_entry_t a_q, b_q;
  bfsp_pkg::vtx_entry_t wr_data;
  logic [bfsp_pkg::VTX_BITS-1:0] rd_addr_a, wr_addr;
  logic                          wr_en;
  logic                          store_full;

  logic [SUM_BITS-1:0]            sum;
  logic [bfsp_pkg::DIST_BITS-1:0] cand;
  logic                           edge_in_range;
  logic                           relax_ok;
  bfsp_pkg::result_t              res;

  assign store_full = (edge_count == bfsp_pkg::ECNT_BITS'(bfsp_pkg::MAX_EDGES));

  // Edge store: appended in load order, read at the relaxation index.
  always_ff @(posedge clk) begin
    if (cmd.edge_wr && !store_full) begin
      edge_mem[edge_count[bfsp_pkg::EDGE_AW-1:0]] <=
        bfsp_pkg::edge_t'(s_tdata[$bits(bfsp_pkg::edge_t)-1:0]);
    end
    e_q <= edge_mem[k];
  end

  // Vertex table: port A reads the tail (or the emitted vertex), port B the head.
  assign rd_addr_a = cmd.rd_vertex ? v : e_q.from;
  assign wr_en     = cmd.init_wr || (cmd.relax_commit && relax_ok);
  assign wr_addr   = cmd.init_wr ? v : e_q.to;

  always_comb begin
    if (cmd.init_wr) begin
      wr_data         = '0;
      wr_data.reach   = (v == src);
    end else begin
      wr_data.reach   = 1'b1;
      wr_data.has_par = 1'b1;
      wr_data.parent  = e_q.from;
      wr_data.cost    = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vtx_mem[wr_addr] <= wr_data;
    end
    a_q <= vtx_mem[rd_addr_a];
    b_q <= vtx_mem[e_q.to];
  end

  // Candidate distance, clamped to the signed 32-bit range.
  assign sum = {a_q.cost[bfsp_pkg::DIST_BITS-1], a_q.cost}
             + {{EXT_BITS{e_q.weight[bfsp_pkg::WEIGHT_BITS-1]}}, e_q.weight};

  always_comb begin
    if (sum[SUM_BITS-1] != sum[SUM_BITS-2]) begin
      cand = sum[SUM_BITS-1] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
    end else begin
      cand = sum[bfsp_pkg::DIST_BITS-1:0];
    end
  end

  assign edge_in_range = ({1'b0, e_q.from} < nv) && ({1'b0, e_q.to} < nv);
  assign relax_ok = edge_in_range && a_q.reach &&
                    (!b_q.reach || ($signed(cand) < $signed(b_q.cost)));

  // Counters and run flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      overflow   <= 1'b0;
      k          <= '0;
      v          <= '0;
      pass       <= '0;
      changed    <= 1'b0;
      neg        <= 1'b0;
    end else begin
      if (cmd.store_clr) begin
        edge_count <= '0;
        overflow   <= 1'b0;
      end else if (cmd.edge_wr) begin
        if (store_full) begin
          overflow <= 1'b1;
        end else begin
          edge_count <= edge_count + 1'b1;
        end
      end
      if (cmd.run_start || cmd.v_clr) begin
        v <= '0;
      end else if (cmd.init_wr || cmd.v_inc) begin
        v <= v + 1'b1;
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.pass_clr) begin
        pass <= bfsp_pkg::VCNT_BITS'(1);
      end else if (cmd.pass_inc) begin
        pass <= pass + 1'b1;
      end
      if (cmd.k_clr) begin
        changed <= 1'b0;
      end else if (cmd.relax_commit && relax_ok) begin
        changed <= 1'b1;
      end
      if (cmd.run_start) begin
        neg <= 1'b0;
      end else if (cmd.neg_set) begin
        neg <= 1'b1;
      end
    end
  end

  // Result register; it holds a result until it is taken.
  always_comb begin
    res                = '0;
    res.vertex         = v;
    res.reachable      = a_q.reach;
    res.distance       = a_q.reach ? a_q.cost : '0;
    res.has_parent     = a_q.reach && a_q.has_par;
    res.parent         = res.has_parent ? a_q.parent : '0;
    res.negative_cycle = neg;
    res.edges_dropped  = overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res;
      m_tlast <= sts.v_last;
    end
  end

  always_comb begin
    sts.v_last      = ({1'b0, v} == (nv - 1'b1));
    sts.edges_empty = (edge_count == '0);
    sts.k_last      = ({1'b0, k} == (edge_count - 1'b1));
    sts.relax_ok    = relax_ok;
    sts.changed_any = changed || relax_ok;
    sts.pass_last   = (pass == (nv - 1'b1));
    sts.src_ok      = ({1'b0, src} < nv);
    sts.nv_one      = (nv == bfsp_pkg::VCNT_BITS'(1));
    sts.out_free    = !m_tvalid || m_tready;
  end

endmodule

// File: hdl/bellman_ford_shortest_path.sv
// Bellman-Ford shortest path block. Edge appends are taken back to back while idle.
// A run clears the table vertex by vertex, makes up to nv - 1 relaxation passes and
// a check pass over the E stored edges (nv vertices), each edge visit going through
// the edge store and vertex table read ports, and emits one result per vertex.
// No further request is accepted during a run. Synchronous active-high reset
// empties the edge store and loads vertex_count = 64 and source_vertex = 0.
module bellman_ford_shortest_path (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [bfsp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // Request side.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: edge_from[5:0], edge_to[11:6], edge_weight[27:12], zero fill [31:28]
  input  logic [bfsp_pkg::S_DATA_BITS-1:0]     s_tdata,
  // s_tuser: func (0 append edge, 1 run and emit results)
  input  logic                                 s_tuser,
  // Result side.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: vertex[5:0], distance[37:6], reachable[38], has_parent[39],
  //          parent[45:40], negative_cycle[46], edges_dropped[47]
  output logic [bfsp_pkg::M_DATA_BITS-1:0]     m_tdata,
  output logic                                 m_tlast
);

  // Configuration registers. The user must see they are only written while the block is idle; nothing enforces it.
  logic [bfsp_pkg::VCNT_BITS-1:0] vertex_count;
  logic [bfsp_pkg::VTX_BITS-1:0]  source_vertex;
  logic [bfsp_pkg::VCNT_BITS-1:0] nv;

  bfsp_pkg::cmd_t cmd;
  bfsp_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= bfsp_pkg::VCOUNT_RESET;
      source_vertex <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfsp_pkg::CFG_VERTEX_COUNT: begin
          vertex_count <= cfg_data[bfsp_pkg::VCNT_BITS-1:0];
        end
        bfsp_pkg::CFG_SOURCE_VERTEX: begin
          source_vertex <= cfg_data[bfsp_pkg::VTX_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The vertex count in use: zero counts as one vertex, and anything above the
  // table size is held to the table size.
  always_comb begin
    if (vertex_count == '0) begin
      nv = bfsp_pkg::VCNT_BITS'(1);
    end else if (vertex_count > bfsp_pkg::VCOUNT_RESET) begin
      nv = bfsp_pkg::VCOUNT_RESET;
    end else begin
      nv = vertex_count;
    end
  end

  // The controller walks the run: table clear, relaxation passes over the edge
  // store, the final negative-cycle check pass, and one result per vertex.
  bfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the edge store, the vertex table, the counters and the
  // result register, which lets a finished result wait while new edge
  // requests are taken.
  bfsp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .nv       (nv),
    .src      (source_vertex),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: test/tb_bellman_ford_shortest_path.sv
// Self-checking testbench for the Bellman-Ford shortest path block.
// Holds a path scoreboard class with its own solver and the top module that drives
// edge and run requests. Depends on bfsp_pkg and bellman_ford_shortest_path.

class path_scoreboard;
  typedef struct packed {
    bfsp_pkg::result_t fields;
    logic              last;
  } vertex_report_t;

  logic [bfsp_pkg::VTX_BITS-1:0]  tail_v   [bfsp_pkg::MAX_EDGES];
  logic [bfsp_pkg::VTX_BITS-1:0]  head_v   [bfsp_pkg::MAX_EDGES];
  int                             weight_v [bfsp_pkg::MAX_EDGES];
  int                             edge_total;
  bit                             store_overflow;
  logic [bfsp_pkg::VCNT_BITS-1:0] vertex_count;
  logic [bfsp_pkg::VTX_BITS-1:0]  source_vertex;
  int                             cost    [bfsp_pkg::MAX_VERTICES];
  bit                             reached [bfsp_pkg::MAX_VERTICES];
  bit                             linked  [bfsp_pkg::MAX_VERTICES];
  logic [bfsp_pkg::VTX_BITS-1:0]  pred    [bfsp_pkg::MAX_VERTICES];
  vertex_report_t                 expected_q [$];
  int                             failures;

  function new();
    edge_total     = 0;
    store_overflow = 1'b0;
    vertex_count   = bfsp_pkg::VCOUNT_RESET;
    source_vertex  = '0;
    failures       = 0;
  endfunction

  function void write_reg(logic [bfsp_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [bfsp_pkg::CFG_DATA_BITS-1:0] value);
    if (idx == bfsp_pkg::CFG_VERTEX_COUNT) begin
      vertex_count = value;
    end else begin
      source_vertex = value[bfsp_pkg::VTX_BITS-1:0];
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Tries stored edge k; returns 1 if it lowers the head distance, and applies
  // the update when commit is set. Candidates clamp to 32 bits before compare.
  function bit relaxes(int k, int nv, bit commit);
    int     a;
    int     b;
    longint cand;
    a = tail_v[k];
    b = head_v[k];
    if (a >= nv || b >= nv || !reached[a]) return 1'b0;
    cand = longint'(cost[a]) + longint'(weight_v[k]);
    if (cand > longint'($signed(bfsp_pkg::DIST_MAX))) begin
      cand = longint'($signed(bfsp_pkg::DIST_MAX));
    end else if (cand < longint'($signed(bfsp_pkg::DIST_MIN))) begin
      cand = longint'($signed(bfsp_pkg::DIST_MIN));
    end
    if (reached[b] && cand >= cost[b]) return 1'b0;
    if (commit) begin
      cost[b]    = int'(cand);
      pred[b]    = bfsp_pkg::VTX_BITS'(a);
      linked[b]  = 1'b1;
      reached[b] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Called for every accepted request: appends store an edge, runs solve and
  // queue one report per vertex.
  function void note_request(logic func, logic [bfsp_pkg::VTX_BITS-1:0] t,
                             logic [bfsp_pkg::VTX_BITS-1:0] h,
                             logic [bfsp_pkg::WEIGHT_BITS-1:0] w);
    int             nv;
    int             pass;
    bit             moved;
    bit             neg;
    vertex_report_t rep;
    if (func == bfsp_pkg::FUNC_APPEND) begin
      if (edge_total < bfsp_pkg::MAX_EDGES) begin
        tail_v[edge_total]   = t;
        head_v[edge_total]   = h;
        weight_v[edge_total] = int'($signed(w));
        edge_total++;
      end else begin
        store_overflow = 1'b1;
      end
      return;
    end
    if (vertex_count == 0) nv = 1;
    else if (vertex_count > bfsp_pkg::MAX_VERTICES) nv = bfsp_pkg::MAX_VERTICES;
    else nv = int'(vertex_count);
    neg = 1'b0;
    for (int v = 0; v < nv; v++) begin
      cost[v]    = 0;
      reached[v] = 1'b0;
      linked[v]  = 1'b0;
      pred[v]    = '0;
    end
    if (source_vertex < nv) begin
      reached[source_vertex] = 1'b1;
      for (pass = 1; pass < nv; pass++) begin
        moved = 1'b0;
        for (int k = 0; k < edge_total; k++) begin
          if (relaxes(k, nv, 1'b1)) moved = 1'b1;
        end
        if (!moved) break;
      end
      for (int k = 0; k < edge_total && !neg; k++) neg = relaxes(k, nv, 1'b0);
    end
    for (int v = 0; v < nv; v++) begin
      rep.fields.vertex         = bfsp_pkg::VTX_BITS'(v);
      rep.fields.distance       = reached[v] ? cost[v] : 0;
      rep.fields.reachable      = reached[v];
      rep.fields.has_parent     = reached[v] && linked[v];
      rep.fields.parent         = (reached[v] && linked[v]) ? pred[v] : '0;
      rep.fields.negative_cycle = neg;
      rep.fields.edges_dropped  = store_overflow;
      rep.last                  = (v + 1 == nv);
      expected_q = {expected_q, rep};
    end
    edge_total     = 0;
    store_overflow = 1'b0;
  endfunction

  function void compare(string field, int vtx, logic signed [63:0] want,
                        logic signed [63:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: vertex %0d %s expected %0d actual %0d", $time, vtx, field, want, got);
    end
  endfunction

  function void check_result(logic [bfsp_pkg::M_DATA_BITS-1:0] data, logic last);
    bfsp_pkg::result_t got;
    vertex_report_t    want;
    got = data;
    if (expected_q.size() == 0) begin
      failures++;
      $display("%0t: result expected none actual data %h last %b", $time, data, last);
      return;
    end
    want = expected_q.pop_front();
    compare("vertex", want.fields.vertex, want.fields.vertex, got.vertex);
    compare("distance", want.fields.vertex, $signed(want.fields.distance),
            $signed(got.distance));
    compare("reachable", want.fields.vertex, want.fields.reachable, got.reachable);
    compare("has_parent", want.fields.vertex, want.fields.has_parent, got.has_parent);
    compare("parent", want.fields.vertex, want.fields.parent, got.parent);
    compare("negative_cycle", want.fields.vertex, want.fields.negative_cycle,
            got.negative_cycle);
    compare("edges_dropped", want.fields.vertex, want.fields.edges_dropped,
            got.edges_dropped);
    compare("last", want.fields.vertex, want.last, last);
  endfunction
endclass

module tb_bellman_ford_shortest_path;

  logic                                   clk       = 1'b0;
  logic                                   rst       = 1'b1;
  logic                                   cfg_we    = 1'b0;
  logic [bfsp_pkg::CFG_IDX_BITS-1:0]      cfg_index = '0;
  logic [bfsp_pkg::CFG_DATA_BITS-1:0]     cfg_data  = '0;
  logic                                   s_tvalid  = 1'b0;
  logic                                   s_tready;
  // s_tdata: edge_from[5:0], edge_to[11:6], edge_weight[27:12], zero fill [31:28]
  logic [bfsp_pkg::S_DATA_BITS-1:0]       s_tdata   = '0;
  // s_tuser: func
  logic                                   s_tuser   = 1'b0;
  logic                                   m_tvalid;
  logic                                   m_tready  = 1'b0;
  // m_tdata: vertex, distance, reachable, has_parent, parent, negative_cycle,
  //          edges_dropped
  logic [bfsp_pkg::M_DATA_BITS-1:0]       m_tdata;
  logic                                   m_tlast;

  path_scoreboard board = new();

  // When set, both sides skip their random gaps for the current stretch.
  bit no_idle   = 1'b0;
  // A nonzero value makes the result sink hold off once; the value sets its length.
  int sink_hold = 0;
  // Number of requests accepted so far.
  int sent_items = 0;

  bellman_ford_shortest_path dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  // Results are sampled at the edge itself, so the values seen are the ones
  // the block presented during the preceding cycle.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
  end

  // Offers one request after a random gap and waits for the handshake. The
  // scoreboard learns about the request only once the block has taken it.
  task automatic send_request(input logic func,
                              input logic [bfsp_pkg::VTX_BITS-1:0] t,
                              input logic [bfsp_pkg::VTX_BITS-1:0] h,
                              input logic [bfsp_pkg::WEIGHT_BITS-1:0] w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= bfsp_pkg::S_DATA_BITS'({w, h, t});
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    board.note_request(func, t, h, w);
    sent_items++;
  endtask

  task automatic add_edge(input logic [bfsp_pkg::VTX_BITS-1:0] t,
                          input logic [bfsp_pkg::VTX_BITS-1:0] h,
                          input logic [bfsp_pkg::WEIGHT_BITS-1:0] w);
    send_request(bfsp_pkg::FUNC_APPEND, t, h, w);
  endtask

  // The edge fields are ignored on a run, so they carry random noise.
  task automatic run_solve();
    send_request(bfsp_pkg::FUNC_RUN, bfsp_pkg::VTX_BITS'($urandom),
                 bfsp_pkg::VTX_BITS'($urandom), bfsp_pkg::WEIGHT_BITS'($urandom));
  endtask

  // Stops offering requests and waits until every expected result has come
  // back, then lets the block settle into idle before returning.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the vertex count, then the source vertex; only call while idle.
  task automatic configure(input logic [bfsp_pkg::CFG_DATA_BITS-1:0] count,
                           input logic [bfsp_pkg::VTX_BITS-1:0] src);
    cfg_we    <= 1'b1;
    cfg_index <= bfsp_pkg::CFG_VERTEX_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_index <= bfsp_pkg::CFG_SOURCE_VERTEX;
    cfg_data  <= bfsp_pkg::CFG_DATA_BITS'(src);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(bfsp_pkg::CFG_VERTEX_COUNT, count);
    board.write_reg(bfsp_pkg::CFG_SOURCE_VERTEX, bfsp_pkg::CFG_DATA_BITS'(src));
  endtask

  // Mostly a vertex inside the graph in use, sometimes any vertex at all so
  // that out-of-range endpoints show up as well.
  function automatic logic [bfsp_pkg::VTX_BITS-1:0] pick_vertex(int span);
    if ($urandom_range(0, 9) == 0) return bfsp_pkg::VTX_BITS'($urandom_range(0, 63));
    return bfsp_pkg::VTX_BITS'($urandom_range(0, span - 1));
  endfunction

  // Result sink: random gaps before each result, and one long hold-off when
  // asked, during which the block has to stop taking new requests. The
  // hold-off count starts once a result is waiting.
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        while (!m_tvalid) @(posedge clk);
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready) && sink_hold == 0) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                                 span;
    int                                 n_edges;
    logic [bfsp_pkg::CFG_DATA_BITS-1:0] nv_set;
    logic [bfsp_pkg::VTX_BITS-1:0]      src_set;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still hold their reset values: 64 vertices from vertex 0.
    add_edge(6'd0, 6'd5, -16'sd7);
    run_solve();
    drain();

    // Small graph with an out-of-range edge, a zero self-loop and the weight
    // extremes; the cycle through vertex 0 has positive total weight.
    configure(7'd4, 6'd0);
    add_edge(6'd0, 6'd1, 16'sd5);
    add_edge(6'd1, 6'd2, -16'sd3);
    add_edge(6'd0, 6'd2, 16'sd10);
    add_edge(6'd2, 6'd3, 16'sd32767);
    add_edge(6'd3, 6'd0, -16'sd32768);
    add_edge(6'd5, 6'd1, 16'sd7);
    add_edge(6'd1, 6'd1, 16'sd0);
    add_edge(6'd63, 6'd63, -16'sd1);
    run_solve();
    drain();

    // Three-vertex negative cycle reachable from the source.
    configure(7'd3, 6'd0);
    add_edge(6'd0, 6'd1, -16'sd1);
    add_edge(6'd1, 6'd2, -16'sd1);
    add_edge(6'd2, 6'd0, -16'sd1);
    run_solve();
    drain();

    // A vertex count of zero acts as a single vertex: no relaxation passes,
    // yet the cycle check still catches a negative self-loop.
    configure(7'd0, 6'd0);
    add_edge(6'd0, 6'd0, -16'sd1);
    run_solve();
    drain();

    // A count above the maximum saturates to 64; source is the top vertex.
    configure(7'd127, 6'd63);
    add_edge(6'd63, 6'd0, -16'sd32768);
    add_edge(6'd0, 6'd62, 16'sd32767);
    run_solve();
    drain();

    // Source outside the graph: nothing is reachable.
    configure(7'd5, 6'd10);
    add_edge(6'd10, 6'd1, 16'sd1);
    run_solve();
    drain();

    // Run with an empty edge store.
    configure(7'd2, 6'd1);
    run_solve();
    drain();

    // Random graphs: mostly small vertex counts and well-formed edges with
    // small weights, some full-range weights and stray endpoints.
    span = 2;
    for (int group = 0; sent_items < 470; group++) begin
      // Group 5 follows the long hold-off and must keep offering requests.
      if (group == 0 || (group != 5 && $urandom_range(0, 2) == 0)) begin
        drain();
        case ($urandom_range(0, 9))
          0: nv_set = bfsp_pkg::CFG_DATA_BITS'($urandom_range(0, 127));
          1: nv_set = 7'd64;
          2: nv_set = 7'd1;
          default: nv_set = bfsp_pkg::CFG_DATA_BITS'($urandom_range(2, 10));
        endcase
        span = (nv_set == 0) ? 1 :
               (nv_set > bfsp_pkg::MAX_VERTICES) ? bfsp_pkg::MAX_VERTICES : int'(nv_set);
        if ($urandom_range(0, 4) == 0) begin
          src_set = bfsp_pkg::VTX_BITS'($urandom_range(0, 63));
        end else begin
          src_set = bfsp_pkg::VTX_BITS'($urandom_range(0, span - 1));
        end
        configure(nv_set, src_set);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      n_edges = $urandom_range(0, (span > 10) ? 20 : 12);
      for (int i = 0; i < n_edges; i++) begin
        add_edge(pick_vertex(span), pick_vertex(span),
                 ($urandom_range(0, 3) == 0) ?
                   bfsp_pkg::WEIGHT_BITS'($urandom_range(0, 65535)) :
                   bfsp_pkg::WEIGHT_BITS'($urandom_range(0, 48) - 8));
      end
      // Hold the results back for a long while; the next group's edges keep
      // being offered and the block has to stall its request side.
      if (group == 4) sink_hold = 400;
      run_solve();
    end

    drain();
    repeat (16) @(posedge clk);
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #(3_000_000 * 20);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
hdl/bfsp_pkg.sv
hdl/bfsp_ctrl.sv
hdl/bfsp_dp.sv
hdl/bellman_ford_shortest_path.sv
test/tb_bellman_ford_shortest_path.sv
